[rtl/core/clt_pkg.sv]
// ----------------------------------------------------------------------------
// clt_pkg - shared types and constants of the command-line tokenizer
// Field widths, result and error codes, character codes, queue entry format.
// ----------------------------------------------------------------------------
package clt_pkg;

  localparam int MAX_ARGS     = 16;
  localparam int MAX_LENGTH   = 1024;
  localparam int QUEUE_DEPTH  = 4;
  localparam int MAX_ITEM_RES = 4;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = 4;
  localparam int LEN_W  = 11;
  localparam int CNT_W  = 5;

  localparam logic [BYTE_W-1:0] CH_TAB_LO = 8'h09;
  localparam logic [BYTE_W-1:0] CH_TAB_HI = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
  localparam logic [BYTE_W-1:0] CH_AT     = 8'h40;
  localparam logic [BYTE_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UP_F   = 8'h46;
  localparam logic [BYTE_W-1:0] CH_UP_X   = 8'h58;
  localparam logic [BYTE_W-1:0] CH_LO_A   = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LO_F   = 8'h66;
  localparam logic [BYTE_W-1:0] CH_LO_X   = 8'h78;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_ARG_END,
    KIND_ACCEPT,
    KIND_ERROR
  } kind_t;

  typedef enum logic [2:0] {
    ERR_EMPTY,
    ERR_TOO_MANY,
    ERR_NO_NUMBER,
    ERR_BAD_CODE,
    ERR_TRAIL_ESC,
    ERR_OPEN_QUOTE
  } err_t;

  // Classified request as it sits in the queue
  typedef struct packed {
    logic              is_end;
    logic [BYTE_W-1:0] code;
    logic              is_space;
    logic              is_ws;
    logic              is_sign;
    logic              is_dec;
    logic              is_hex;
    logic [3:0]        digit;
  } item_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] byte_value;
    logic [IDX_W-1:0]  arg_index;
    logic [LEN_W-1:0]  arg_length;
    logic [CNT_W-1:0]  arg_count;
    err_t              error_code;
    logic              last;
  } res_t;

  function automatic res_t byte_res(logic [BYTE_W-1:0] b, logic [IDX_W-1:0] idx);
    res_t r;
    r = '0;
    r.kind       = KIND_BYTE;
    r.byte_value = b;
    r.arg_index  = idx;
    return r;
  endfunction

  function automatic res_t end_res(logic [IDX_W-1:0] idx, logic [LEN_W-1:0] len);
    res_t r;
    r = '0;
    r.kind       = KIND_ARG_END;
    r.arg_index  = idx;
    r.arg_length = len;
    return r;
  endfunction

  function automatic res_t accept_res(logic [CNT_W-1:0] cnt);
    res_t r;
    r = '0;
    r.kind      = KIND_ACCEPT;
    r.arg_count = cnt;
    r.last      = 1'b1;
    return r;
  endfunction

  function automatic res_t error_res(err_t e);
    res_t r;
    r = '0;
    r.kind       = KIND_ERROR;
    r.error_code = e;
    r.last       = 1'b1;
    return r;
  endfunction

endpackage

[rtl/core/clt_char_if.sv]
// ----------------------------------------------------------------------------
// clt_char_if - character request channel
// Valid/ready channel carrying one message character or an end of message.
// ----------------------------------------------------------------------------
interface clt_char_if;
  import clt_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [BYTE_W-1:0] char_code;

  modport source (output valid, output op, output char_code, input ready);
  modport sink   (input valid, input op, input char_code, output ready);
endinterface

[rtl/core/clt_tok_if.sv]
// ----------------------------------------------------------------------------
// clt_tok_if - token result channel
// Valid/ready channel carrying argument bytes, argument ends and verdicts.
// ----------------------------------------------------------------------------
interface clt_tok_if;
  import clt_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [BYTE_W-1:0] byte_value;
  logic [IDX_W-1:0]  arg_index;
  logic [LEN_W-1:0]  arg_length;
  logic [CNT_W-1:0]  arg_count;
  logic [2:0]        error_code;
  logic              last;

  modport source (output valid, output kind, output byte_value, output arg_index,
                  output arg_length, output arg_count, output error_code,
                  output last, input ready);
  modport sink   (input valid, input kind, input byte_value, input arg_index,
                  input arg_length, input arg_count, input error_code,
                  input last, output ready);
endinterface

[rtl/core/clt_front.sv]
// ----------------------------------------------------------------------------
// clt_front - request intake and character classification
// Accepts character requests while the queue has room and decodes each one.
// ----------------------------------------------------------------------------
module clt_front (
  clt_char_if.sink       chars,
  input  logic           full,
  output logic           push,
  output clt_pkg::item_t item
);
  import clt_pkg::*;

  logic [BYTE_W-1:0] c;
  logic              up_hex;
  logic              lo_hex;

  assign c      = chars.char_code;
  assign up_hex = (c >= CH_UP_A) && (c <= CH_UP_F);
  assign lo_hex = (c >= CH_LO_A) && (c <= CH_LO_F);

  assign chars.ready = !full;
  assign push        = chars.valid && !full;

  always_comb begin
    item          = '0;
    item.is_end   = chars.op || (c == '0);
    item.code     = c;
    item.is_space = (c == CH_SPACE);
    item.is_ws    = (c == CH_SPACE) || ((c >= CH_TAB_LO) && (c <= CH_TAB_HI));
    item.is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
    item.is_dec   = (c >= CH_ZERO) && (c <= CH_NINE);
    item.is_hex   = item.is_dec || up_hex || lo_hex;
    // letters a-f / A-F carry 1..6 in the low nibble
    item.digit    = item.is_dec ? c[3:0] : (c[3:0] + 4'd9);
  end

endmodule

[rtl/core/clt_queue.sv]
// ----------------------------------------------------------------------------
// clt_queue - short request queue between intake and parser
// Small circular buffer of classified requests; push and pop may share a cycle.
// ----------------------------------------------------------------------------
module clt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  clt_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output clt_pkg::item_t head
);
  import clt_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  item_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  assign full       = (fill == FILL_W'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= PTR_W'((32'(wr_ptr) + 1) % QUEUE_DEPTH);
      end
      if (pop) begin
        rd_ptr <= PTR_W'((32'(rd_ptr) + 1) % QUEUE_DEPTH);
      end
      if (push && !pop) begin
        fill <= fill + FILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

endmodule

[rtl/core/clt_back.sv]
// ----------------------------------------------------------------------------
// clt_back - parser and result sequencer
// Runs the split/quote/escape/number rules on the queue head and hands its
// results to the output register one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module clt_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_data,
  input  logic           head_valid,
  input  clt_pkg::item_t head,
  output logic           pop,
  clt_tok_if.source      tokens
);
  import clt_pkg::*;

  localparam int SEL_W  = $clog2(MAX_ITEM_RES);
  localparam int NRES_W = $clog2(MAX_ITEM_RES + 1);
  localparam int ACC_W  = 9;
  localparam int WIDE_W = ACC_W + 4;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LENGTH);
  localparam logic [ACC_W-1:0] ACC_SAT = 9'd256;

  typedef enum logic [2:0] {
    PH_NORMAL,
    PH_ESC,
    PH_NUM_WS,
    PH_NUM_SIGN,
    PH_NUM_ZERO,
    PH_NUM_XL,
    PH_NUM_XU,
    PH_NUM_DIGITS
  } phase_t;

  typedef enum logic [1:0] {
    RAD_DEC,
    RAD_OCT,
    RAD_HEX
  } radix_t;

  // parser state
  phase_t            ph;
  logic              quoted;
  logic              sp_pend;
  logic [IDX_W-1:0]  arg;
  logic [LEN_W-1:0]  len;
  logic [ACC_W-1:0]  acc;
  radix_t            rad;
  logic              neg;
  logic              err;
  logic              started;
  logic              space_mode;

  phase_t            ph_next;
  logic              quoted_next;
  logic              sp_pend_next;
  logic [IDX_W-1:0]  arg_next;
  logic [LEN_W-1:0]  len_next;
  logic [ACC_W-1:0]  acc_next;
  radix_t            rad_next;
  logic              neg_next;
  logic              err_next;
  logic              started_next;

  res_t              res [MAX_ITEM_RES];
  logic [NRES_W-1:0] nres;

  logic [SEL_W-1:0]  sel;
  logic              out_valid;
  res_t              out_q;
  logic              can_load;
  logic              load;
  logic              last_res;

  function automatic logic [LEN_W-1:0] len_inc(logic [LEN_W-1:0] l);
    return (l < LEN_MAX) ? (l + LEN_W'(1)) : l;
  endfunction

  function automatic logic code_ok(logic [ACC_W-1:0] a, logic n);
    return !((a > ACC_W'(255)) || (n && (a != '0)));
  endfunction

  always_comb begin : step_calc
    logic              run_normal;
    logic              brk_ok;
    logic              dig_ok;
    logic [WIDE_W-1:0] acc_wide;
    logic [BYTE_W-1:0] xc;

    ph_next      = ph;
    quoted_next  = quoted;
    sp_pend_next = sp_pend;
    arg_next     = arg;
    len_next     = len;
    acc_next     = acc;
    rad_next     = rad;
    neg_next     = neg;
    err_next     = err;
    started_next = started;
    nres         = '0;
    for (int i = 0; i < MAX_ITEM_RES; i++) begin
      res[i] = '0;
    end
    run_normal = 1'b0;
    brk_ok     = 1'b1;
    dig_ok     = 1'b0;
    acc_wide   = '0;
    xc         = (ph == PH_NUM_XL) ? CH_LO_X : CH_UP_X;

    if (!head.is_end) begin
      started_next = 1'b1;
      if (!err) begin
        unique case (ph)
          PH_NORMAL: begin
            run_normal = 1'b1;
          end
          PH_ESC: begin
            ph_next = PH_NORMAL;
            res[nres[SEL_W-1:0]] = byte_res(head.code, arg_next);
            nres = nres + NRES_W'(1);
            len_next = len_inc(len_next);
          end
          PH_NUM_WS, PH_NUM_SIGN: begin
            if ((ph == PH_NUM_WS) && head.is_ws) begin
              // skip leading whitespace
            end else if ((ph == PH_NUM_WS) && head.is_sign) begin
              neg_next = (head.code == CH_MINUS);
              ph_next  = PH_NUM_SIGN;
            end else if (head.code == CH_ZERO) begin
              acc_next = '0;
              ph_next  = PH_NUM_ZERO;
            end else if (head.is_dec) begin
              acc_next = ACC_W'(head.digit);
              rad_next = RAD_DEC;
              ph_next  = PH_NUM_DIGITS;
            end else begin
              res[nres[SEL_W-1:0]] = error_res(ERR_NO_NUMBER);
              nres = nres + NRES_W'(1);
              err_next = 1'b1;
            end
          end
          PH_NUM_ZERO, PH_NUM_DIGITS: begin
            if (ph == PH_NUM_ZERO) begin
              dig_ok = head.is_dec && !head.digit[3];
            end else begin
              unique case (rad)
                RAD_OCT: dig_ok = head.is_dec && !head.digit[3];
                RAD_HEX: dig_ok = head.is_hex;
                default: dig_ok = head.is_dec;
              endcase
            end
            if ((ph == PH_NUM_ZERO) && (head.code == CH_LO_X)) begin
              ph_next = PH_NUM_XL;
            end else if ((ph == PH_NUM_ZERO) && (head.code == CH_UP_X)) begin
              ph_next = PH_NUM_XU;
            end else if (dig_ok && (ph == PH_NUM_ZERO)) begin
              acc_next = ACC_W'(head.digit);
              rad_next = RAD_OCT;
              ph_next  = PH_NUM_DIGITS;
            end else if (dig_ok) begin
              unique case (rad)
                RAD_OCT: acc_wide = {1'b0, acc, 3'b000};
                RAD_HEX: acc_wide = {acc, 4'b0000};
                default: acc_wide = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
              endcase
              acc_wide = acc_wide + WIDE_W'(head.digit);
              acc_next = (acc_wide > WIDE_W'(ACC_SAT)) ? ACC_SAT : acc_wide[ACC_W-1:0];
            end else begin
              // number ends; this byte then goes through the normal rules
              ph_next = PH_NORMAL;
              if (code_ok(acc, neg)) begin
                res[nres[SEL_W-1:0]] = byte_res(acc[BYTE_W-1:0], arg_next);
                nres = nres + NRES_W'(1);
                len_next = len_inc(len_next);
                run_normal = 1'b1;
              end else begin
                res[nres[SEL_W-1:0]] = error_res(ERR_BAD_CODE);
                nres = nres + NRES_W'(1);
                err_next = 1'b1;
              end
            end
          end
          PH_NUM_XL, PH_NUM_XU: begin
            if (head.is_hex) begin
              acc_next = ACC_W'(head.digit);
              rad_next = RAD_HEX;
              ph_next  = PH_NUM_DIGITS;
            end else begin
              // bare 0x: byte 0, then the x itself, then this byte
              acc_next = '0;
              ph_next  = PH_NORMAL;
              res[nres[SEL_W-1:0]] = byte_res('0, arg_next);
              nres = nres + NRES_W'(1);
              len_next = len_inc(len_next);
              res[nres[SEL_W-1:0]] = byte_res(xc, arg_next);
              nres = nres + NRES_W'(1);
              len_next = len_inc(len_next);
              run_normal = 1'b1;
            end
          end
        endcase

        if (run_normal) begin
          if (sp_pend_next && !head.is_space) begin
            sp_pend_next = 1'b0;
            if (({1'b0, arg_next} + CNT_W'(1)) >= CNT_W'(MAX_ARGS)) begin
              res[nres[SEL_W-1:0]] = error_res(ERR_TOO_MANY);
              nres = nres + NRES_W'(1);
              err_next = 1'b1;
              brk_ok = 1'b0;
            end else begin
              res[nres[SEL_W-1:0]] = end_res(arg_next, len_next);
              nres = nres + NRES_W'(1);
              arg_next = arg_next + IDX_W'(1);
              len_next = '0;
            end
          end
          if (brk_ok) begin
            priority if (head.is_space) begin
              if (quoted_next) begin
                res[nres[SEL_W-1:0]] = byte_res(head.code, arg_next);
                nres = nres + NRES_W'(1);
                len_next = len_inc(len_next);
              end else if (space_mode) begin
                sp_pend_next = 1'b1;
              end else if (({1'b0, arg_next} + CNT_W'(1)) >= CNT_W'(MAX_ARGS)) begin
                res[nres[SEL_W-1:0]] = error_res(ERR_TOO_MANY);
                nres = nres + NRES_W'(1);
                err_next = 1'b1;
              end else begin
                res[nres[SEL_W-1:0]] = end_res(arg_next, len_next);
                nres = nres + NRES_W'(1);
                arg_next = arg_next + IDX_W'(1);
                len_next = '0;
              end
            end else if (head.code == CH_SLASH) begin
              ph_next  = PH_NUM_WS;
              acc_next = '0;
              rad_next = RAD_DEC;
              neg_next = 1'b0;
            end else if (head.code == CH_AT) begin
              ph_next = PH_ESC;
            end else if (head.code == CH_QUOTE) begin
              quoted_next = !quoted_next;
            end else begin
              res[nres[SEL_W-1:0]] = byte_res(head.code, arg_next);
              nres = nres + NRES_W'(1);
              len_next = len_inc(len_next);
            end
          end
        end
      end
    end else begin
      if (err) begin
        // rest of a failed message was dropped; end clears silently
      end else if (!started) begin
        res[nres[SEL_W-1:0]] = error_res(ERR_EMPTY);
        nres = nres + NRES_W'(1);
      end else begin
        unique case (ph)
          PH_ESC: begin
            res[nres[SEL_W-1:0]] = error_res(ERR_TRAIL_ESC);
            nres = nres + NRES_W'(1);
            err_next = 1'b1;
          end
          PH_NUM_WS, PH_NUM_SIGN: begin
            res[nres[SEL_W-1:0]] = error_res(ERR_NO_NUMBER);
            nres = nres + NRES_W'(1);
            err_next = 1'b1;
          end
          PH_NUM_ZERO, PH_NUM_DIGITS: begin
            if (code_ok(acc, neg)) begin
              res[nres[SEL_W-1:0]] = byte_res(acc[BYTE_W-1:0], arg_next);
              nres = nres + NRES_W'(1);
              len_next = len_inc(len_next);
            end else begin
              res[nres[SEL_W-1:0]] = error_res(ERR_BAD_CODE);
              nres = nres + NRES_W'(1);
              err_next = 1'b1;
            end
          end
          PH_NUM_XL, PH_NUM_XU: begin
            res[nres[SEL_W-1:0]] = byte_res('0, arg_next);
            nres = nres + NRES_W'(1);
            len_next = len_inc(len_next);
            res[nres[SEL_W-1:0]] = byte_res(xc, arg_next);
            nres = nres + NRES_W'(1);
            len_next = len_inc(len_next);
          end
          PH_NORMAL: begin
          end
        endcase
        if (!err_next) begin
          if (quoted) begin
            res[nres[SEL_W-1:0]] = error_res(ERR_OPEN_QUOTE);
            nres = nres + NRES_W'(1);
          end else begin
            res[nres[SEL_W-1:0]] = end_res(arg_next, len_next);
            nres = nres + NRES_W'(1);
            res[nres[SEL_W-1:0]] = accept_res({1'b0, arg_next} + CNT_W'(1));
            nres = nres + NRES_W'(1);
          end
        end
      end
      // every end of message returns the parser to its idle state
      ph_next      = PH_NORMAL;
      quoted_next  = 1'b0;
      sp_pend_next = 1'b0;
      arg_next     = '0;
      len_next     = '0;
      acc_next     = '0;
      rad_next     = RAD_DEC;
      neg_next     = 1'b0;
      err_next     = 1'b0;
      started_next = 1'b0;
    end
  end

  assign can_load = !out_valid || tokens.ready;
  assign last_res = ((NRES_W'(sel) + NRES_W'(1)) == nres);
  assign load     = head_valid && (nres != '0) && can_load;
  assign pop      = head_valid && ((nres == '0) || (can_load && last_res));

  always_ff @(posedge clk) begin
    if (rst) begin
      ph         <= PH_NORMAL;
      quoted     <= 1'b0;
      sp_pend    <= 1'b0;
      arg        <= '0;
      len        <= '0;
      acc        <= '0;
      rad        <= RAD_DEC;
      neg        <= 1'b0;
      err        <= 1'b0;
      started    <= 1'b0;
      space_mode <= 1'b1;
      sel        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        space_mode <= cfg_data;
      end
      if (pop) begin
        ph      <= ph_next;
        quoted  <= quoted_next;
        sp_pend <= sp_pend_next;
        arg     <= arg_next;
        len     <= len_next;
        acc     <= acc_next;
        rad     <= rad_next;
        neg     <= neg_next;
        err     <= err_next;
        started <= started_next;
        sel     <= '0;
      end else if (load) begin
        sel <= sel + SEL_W'(1);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (tokens.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_q <= res[sel];
    end
  end

  assign tokens.valid      = out_valid;
  assign tokens.kind       = out_q.kind;
  assign tokens.byte_value = out_q.byte_value;
  assign tokens.arg_index  = out_q.arg_index;
  assign tokens.arg_length = out_q.arg_length;
  assign tokens.arg_count  = out_q.arg_count;
  assign tokens.error_code = out_q.error_code;
  assign tokens.last       = out_q.last;

endmodule

[rtl/core/command_line_tokenizer.sv]
// ----------------------------------------------------------------------------
// command_line_tokenizer - splits a command-line message into arguments
// Path: an accepted character request is written into the queue, and its
//   results are loaded from the queue head into the output register.
// Throughput: one request per cycle while the queue has room; a request with
//   k results, at most 4 (end after a bare 0x), holds the parser until all load.
// Reset: synchronous, clears queue, parser state and output; space_mode = 1.
// ----------------------------------------------------------------------------
module command_line_tokenizer (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_data,
  clt_char_if.sink  chars,
  clt_tok_if.source tokens
);
  import clt_pkg::*;

  // intake -> queue
  logic  push;
  logic  full;
  item_t push_item;

  // queue -> parser
  logic  pop;
  logic  head_valid;
  item_t head;

  // Intake: accept a request whenever the queue has a free slot, so the
  // source keeps streaming even while the parser waits on the output side.
  clt_front u_front (
    .chars (chars),
    .full  (full),
    .push  (push),
    .item  (push_item)
  );

  // Decouple intake from the parser; absorbs the extra cycles spent on
  // requests that produce several results.
  clt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Parser: work out all results of the head request, issue them one per cycle
  // into the output register when not stalled, then advance the state and drop the head.
  clt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .tokens     (tokens)
  );

endmodule

[rtl/core/clt_checker.sv]
// ----------------------------------------------------------------------------
// clt_checker - port-level checks of the tokenizer
// Watches the result channel for ordering and field consistency.
// ----------------------------------------------------------------------------
module clt_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 kind,
  input logic [clt_pkg::BYTE_W-1:0] byte_value,
  input logic [clt_pkg::CNT_W-1:0]  arg_count,
  input logic                       last
);
  import clt_pkg::*;

  // nothing comes out in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(byte_value)
      && $stable(last))
    else $error("stalled result changed");

  // only a verdict closes a message
  a_last_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> (kind == KIND_ACCEPT) || (kind == KIND_ERROR))
    else $error("last set on a non-verdict result");

  // verdicts always close the message
  a_verdict_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((kind == KIND_ACCEPT) || (kind == KIND_ERROR)) |-> last)
    else $error("verdict without last");

  // an accept counts at least one and at most the argument limit
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_ACCEPT) |->
      (arg_count != '0) && (arg_count <= CNT_W'(MAX_ARGS)))
    else $error("accept with bad argument count");

endmodule

bind command_line_tokenizer clt_checker u_clt_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (tokens.valid),
  .out_ready  (tokens.ready),
  .kind       (tokens.kind),
  .byte_value (tokens.byte_value),
  .arg_count  (tokens.arg_count),
  .last       (tokens.last)
);

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the command-line tokenizer
// Drives character requests with random gaps, predicts every argument byte,
// argument end and verdict in a behavioral model of the parser, and checks
// each token field by field as it leaves the block under random backpressure.
// ----------------------------------------------------------------------------
module tb_top;
  import clt_pkg::*;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [BYTE_W-1:0] CH_LO_G = 8'h67;

  localparam int PHASE_REQS    = 12;    // minimum random requests per configuration phase
  localparam int SETTLE_CYCLES = 24;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 120;   // long receiver hold-off

  // Parser position inside the current message
  typedef enum logic [2:0] {
    PH_PLAIN,
    PH_ESCAPE,
    PH_WS,
    PH_SIGN,
    PH_ZERO,
    PH_X_LOW,
    PH_X_UP,
    PH_DIGITS
  } scan_t;

  // One character request, optionally carrying a hand-written expectation
  typedef struct {
    logic              op;
    logic [BYTE_W-1:0] ch;
    bit                typed;
    res_t              want;
  } req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic cfg_data;

  clt_char_if char_ch ();
  clt_tok_if  tok_ch ();

  command_line_tokenizer u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .chars    (char_ch),
    .tokens   (tok_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Parser model state
  // --------------------------------------------------------------------------
  bit    collapse_mode;
  scan_t scan;
  bit    quoted;
  bit    gap_pending;
  bit    failed;
  bit    started;
  bit    code_neg;
  int    arg_no;
  int    arg_len;
  int    code_val;
  int    code_base;

  res_t step_res[$];     // tokens caused by the request being modeled
  res_t tokens_due[$];   // tokens still owed by the block, oldest first
  req_t job_q[$];        // requests waiting to be sent

  int n_errors;
  bit burst_send;        // sender skips its gaps
  bit hold_req;          // receiver holds off once for HOLD_CYCLES
  int tx_swap, rx_swap;
  bit tx_quiet, rx_quiet;

  function automatic res_t mk_res(kind_t k, logic [BYTE_W-1:0] b, int idx, int len, int cnt);
    res_t r;
    r = '0;
    r.kind       = k;
    r.byte_value = b;
    r.arg_index  = IDX_W'(idx);
    r.arg_length = LEN_W'(len);
    r.arg_count  = CNT_W'(cnt);
    return r;
  endfunction

  function automatic res_t err_res(err_t e);
    res_t r;
    r = mk_res(KIND_ERROR, 8'h00, 0, 0, 0);
    r.error_code = e;
    r.last       = 1'b1;
    return r;
  endfunction

  function automatic void clear_msg();
    scan        = PH_PLAIN;
    quoted      = 1'b0;
    gap_pending = 1'b0;
    failed      = 1'b0;
    started     = 1'b0;
    code_neg    = 1'b0;
    arg_no      = 0;
    arg_len     = 0;
    code_val    = 0;
    code_base   = 10;
  endfunction

  function automatic void raise_err(err_t e);
    step_res.push_back(err_res(e));
    failed = 1'b1;
  endfunction

  // Emit one argument byte; the length counter saturates but bytes keep flowing
  function automatic void out_byte(logic [BYTE_W-1:0] b);
    step_res.push_back(mk_res(KIND_BYTE, b, arg_no, 0, 0));
    if (arg_len < MAX_LENGTH) arg_len++;
  endfunction

  // Close the open argument; the break past the last slot is an error instead
  function automatic bit split_arg();
    if (arg_no + 1 >= MAX_ARGS) begin
      raise_err(ERR_TOO_MANY);
      return 1'b0;
    end
    step_res.push_back(mk_res(KIND_ARG_END, 8'h00, arg_no, arg_len, 0));
    arg_no++;
    arg_len = 0;
    return 1'b1;
  endfunction

  function automatic int hex_val(logic [BYTE_W-1:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_LO_A && c <= CH_LO_F) return int'(c - CH_LO_A) + 10;
    if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
    return -1;
  endfunction

  function automatic bit is_ws(logic [BYTE_W-1:0] c);
    return c == CH_SPACE || (c >= CH_TAB_LO && c <= CH_TAB_HI);
  endfunction

  // Finish a /N code: anything outside 0..255, or negative and nonzero, is bad
  function automatic bit close_code();
    scan = PH_PLAIN;
    if (code_val > 255 || (code_neg && code_val != 0)) begin
      raise_err(ERR_BAD_CODE);
      return 1'b0;
    end
    out_byte(BYTE_W'(code_val));
    return 1'b1;
  endfunction

  // "0x" with no hex digit: byte 0, then the x itself in its own case
  function automatic bit bare_x();
    logic [BYTE_W-1:0] xc;
    xc = (scan == PH_X_LOW) ? CH_LO_X : CH_UP_X;
    code_val = 0;
    if (!close_code()) return 1'b0;
    out_byte(xc);
    return 1'b1;
  endfunction

  function automatic void plain_char(logic [BYTE_W-1:0] c);
    // a pending collapsed break lands on the first non-space
    if (gap_pending && c != CH_SPACE) begin
      gap_pending = 1'b0;
      if (!split_arg()) return;
    end
    case (c)
      CH_SPACE: begin
        if (quoted) out_byte(c);
        else if (collapse_mode) gap_pending = 1'b1;
        else void'(split_arg());
      end
      CH_SLASH: begin
        scan      = PH_WS;
        code_val  = 0;
        code_base = 10;
        code_neg  = 1'b0;
      end
      CH_AT:    scan = PH_ESCAPE;
      CH_QUOTE: quoted = !quoted;
      default:  out_byte(c);
    endcase
  endfunction

  function automatic bit begin_digit(logic [BYTE_W-1:0] c);
    if (c == CH_ZERO) begin
      code_val = 0;
      scan     = PH_ZERO;
      return 1'b1;
    end
    if (c > CH_ZERO && c <= CH_NINE) begin
      code_val  = int'(c - CH_ZERO);
      code_base = 10;
      scan      = PH_DIGITS;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void predict_char(logic [BYTE_W-1:0] c);
    int d;
    case (scan)
      PH_ESCAPE: begin
        scan = PH_PLAIN;
        out_byte(c);
      end
      PH_WS: begin
        if (!is_ws(c)) begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            code_neg = (c == CH_MINUS);
            scan     = PH_SIGN;
          end else if (!begin_digit(c)) begin
            raise_err(ERR_NO_NUMBER);
          end
        end
      end
      PH_SIGN: begin
        if (!begin_digit(c)) raise_err(ERR_NO_NUMBER);
      end
      PH_ZERO: begin
        if (c == CH_LO_X) scan = PH_X_LOW;
        else if (c == CH_UP_X) scan = PH_X_UP;
        else if (c >= CH_ZERO && c <= CH_ZERO + 8'd7) begin
          code_val  = int'(c - CH_ZERO);
          code_base = 8;
          scan      = PH_DIGITS;
        end else if (close_code()) begin
          plain_char(c);
        end
      end
      PH_X_LOW, PH_X_UP: begin
        d = hex_val(c);
        if (d >= 0) begin
          code_val  = d;
          code_base = 16;
          scan      = PH_DIGITS;
        end else if (bare_x()) begin
          plain_char(c);
        end
      end
      PH_DIGITS: begin
        d = hex_val(c);
        if (d >= 0 && d < code_base) begin
          code_val = code_val * code_base + d;
          if (code_val > 256) code_val = 256;
        end else if (close_code()) begin
          plain_char(c);
        end
      end
      default: begin
        scan = PH_PLAIN;
        plain_char(c);
      end
    endcase
  endfunction

  function automatic void predict_end();
    if (failed) begin
      clear_msg();
      return;
    end
    if (!started) begin
      raise_err(ERR_EMPTY);
      clear_msg();
      return;
    end
    case (scan)
      PH_ESCAPE:         raise_err(ERR_TRAIL_ESC);
      PH_WS, PH_SIGN:    raise_err(ERR_NO_NUMBER);
      PH_ZERO, PH_DIGITS: void'(close_code());
      PH_X_LOW, PH_X_UP: void'(bare_x());
      default: ;
    endcase
    if (!failed) begin
      gap_pending = 1'b0;
      if (quoted) begin
        raise_err(ERR_OPEN_QUOTE);
      end else begin
        step_res.push_back(mk_res(KIND_ARG_END, 8'h00, arg_no, arg_len, 0));
        step_res.push_back(mk_res(KIND_ACCEPT, 8'h00, 0, 0, arg_no + 1));
        step_res[$].last = 1'b1;
      end
    end
    clear_msg();
  endfunction

  // Model one accepted request and book the tokens it owes
  function automatic void book_tokens(req_t r);
    step_res.delete();
    if (r.op == OP_END || r.ch == 8'h00) begin
      predict_end();
    end else begin
      started = 1'b1;
      if (!failed) predict_char(r.ch);
    end
    if (r.typed) tokens_due.push_back(r.want);
    else foreach (step_res[i]) tokens_due.push_back(step_res[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  function automatic void queue_req(logic op, logic [BYTE_W-1:0] ch, bit typed = 1'b0,
                                    res_t want = '0);
    req_t r;
    r.op    = op;
    r.ch    = ch;
    r.typed = typed;
    r.want  = want;
    job_q.push_back(r);
  endfunction

  function automatic logic [BYTE_W-1:0] pick_plain();
    logic [BYTE_W-1:0] c;
    do c = BYTE_W'($urandom_range(1, 255));
    while (c == CH_SPACE || c == CH_QUOTE || c == CH_SLASH || c == CH_AT);
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_hex();
    int d;
    d = $urandom_range(0, 21);
    if (d < 10) return CH_ZERO + BYTE_W'(d);
    if (d < 16) return CH_LO_A + BYTE_W'(d - 10);
    return CH_UP_A + BYTE_W'(d - 16);
  endfunction

  // Close the message with either an end request (random payload) or byte 0
  function automatic void queue_end();
    if ($urandom_range(0, 3) == 0) queue_req(OP_CHAR, 8'h00);
    else queue_req(OP_END, BYTE_W'($urandom_range(0, 255)));
  endfunction

  function automatic void gen_number();
    string edge_txt[7] = '{"255", "256", "0xff", "0X100", "0377", "0400", "0"};
    string s;
    int n;
    queue_req(OP_CHAR, CH_SLASH);
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) begin
      if ($urandom_range(0, 1)) queue_req(OP_CHAR, CH_SPACE);
      else queue_req(OP_CHAR, CH_TAB_LO + BYTE_W'($urandom_range(0, 4)));
    end
    case ($urandom_range(0, 5))
      0: queue_req(OP_CHAR, CH_PLUS);
      1: queue_req(OP_CHAR, CH_MINUS);
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0, 1, 7: begin
        queue_req(OP_CHAR, CH_ZERO + BYTE_W'($urandom_range(1, 9)));
        repeat ($urandom_range(0, 3)) queue_req(OP_CHAR, CH_ZERO + BYTE_W'($urandom_range(0, 9)));
      end
      2: begin
        queue_req(OP_CHAR, CH_ZERO);
        repeat ($urandom_range(0, 3)) queue_req(OP_CHAR, CH_ZERO + BYTE_W'($urandom_range(0, 7)));
      end
      3: begin
        queue_req(OP_CHAR, CH_ZERO);
        queue_req(OP_CHAR, $urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
        repeat ($urandom_range(0, 3)) queue_req(OP_CHAR, pick_hex());
      end
      4: begin
        // leading zero then a digit too big for octal
        queue_req(OP_CHAR, CH_ZERO);
        queue_req(OP_CHAR, CH_ZERO + BYTE_W'($urandom_range(8, 9)));
      end
      5: begin
        s = edge_txt[$urandom_range(0, 6)];
        for (int i = 0; i < s.len(); i++) queue_req(OP_CHAR, s[i]);
      end
      default: ;  // no digits at all
    endcase
  endfunction

  // Well-formed message: plain runs, spaces, quoted parts, escapes and codes
  function automatic void gen_message();
    int n_tok;
    n_tok = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
    repeat (n_tok) begin
      case ($urandom_range(0, 9))
        0, 1, 2: repeat ($urandom_range(1, 4)) queue_req(OP_CHAR, pick_plain());
        3, 4:    repeat ($urandom_range(1, 3)) queue_req(OP_CHAR, CH_SPACE);
        5: begin
          queue_req(OP_CHAR, CH_QUOTE);
          repeat ($urandom_range(1, 3))
            queue_req(OP_CHAR, $urandom_range(0, 1) ? CH_SPACE : pick_plain());
          if ($urandom_range(0, 7) != 0) queue_req(OP_CHAR, CH_QUOTE);
        end
        6: begin
          queue_req(OP_CHAR, CH_AT);
          queue_req(OP_CHAR, BYTE_W'($urandom_range(1, 255)));
        end
        7, 8: gen_number();
        default: queue_req(OP_CHAR, BYTE_W'($urandom_range(1, 255)));
      endcase
    end
    queue_end();
  endfunction

  // Noise: short messages dense in special characters
  function automatic void gen_noise();
    logic [BYTE_W-1:0] pool[8];
    pool = '{CH_SPACE, CH_QUOTE, CH_SLASH, CH_AT, CH_ZERO, CH_LO_X, CH_MINUS, 8'h00};
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 1)) queue_req(OP_CHAR, pool[$urandom_range(0, 6)]);
      else queue_req(OP_CHAR, BYTE_W'($urandom_range(1, 255)));
    end
    queue_end();
  endfunction

  // Enough one-byte arguments to hit the argument limit, or just short of it
  function automatic void gen_many_args();
    int n;
    n = $urandom_range(MAX_ARGS - 2, MAX_ARGS + 2);
    for (int i = 0; i < n; i++) begin
      if (i != 0) repeat ($urandom_range(1, 2)) queue_req(OP_CHAR, CH_SPACE);
      queue_req(OP_CHAR, pick_plain());
    end
    queue_end();
  endfunction

  // Gap draw: stretches of back-to-back traffic between random 0..13 waits
  function automatic int pick_gap(inout int until_swap, inout bit quiet);
    if (until_swap == 0) begin
      quiet      = ($urandom_range(0, 3) == 0);
      until_swap = 16;
    end
    until_swap--;
    return quiet ? 0 : $urandom_range(0, 13);
  endfunction

  // --------------------------------------------------------------------------
  // Channel drivers
  // --------------------------------------------------------------------------

  // Offer one request and hold it until the block takes it
  task automatic send_req(input req_t r);
    int gap;
    gap = burst_send ? 0 : pick_gap(tx_swap, tx_quiet);
    if (gap != 0) begin
      char_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_ch.valid     <= 1'b1;
    char_ch.op        <= r.op;
    char_ch.char_code <= r.ch;
    do @(posedge clk); while (!char_ch.ready);
    book_tokens(r);
  endtask

  task automatic run_jobs();
    while (job_q.size() != 0) send_req(job_q.pop_front());
    char_ch.valid <= 1'b0;
  endtask

  // Wait out every owed token, then the pipeline, so that requests with no
  // token (collapsed spaces, quotes) have also left the queue
  task automatic settle();
    int waited;
    waited = 0;
    while (tokens_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (tokens_due.size() != 0) begin
      $error("%0d expected tokens never arrived", tokens_due.size());
      n_errors++;
      tokens_due.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_space_mode(input bit v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    collapse_mode = v;
  endtask

  function automatic void cmp_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  task automatic check_token();
    res_t want;
    if (tokens_due.size() == 0) begin
      $error("unexpected token: kind %0d byte %0d", tok_ch.kind, tok_ch.byte_value);
      n_errors++;
      return;
    end
    want = tokens_due.pop_front();
    cmp_field("kind", 16'(want.kind), 16'(tok_ch.kind));
    cmp_field("byte_value", 16'(want.byte_value), 16'(tok_ch.byte_value));
    cmp_field("arg_index", 16'(want.arg_index), 16'(tok_ch.arg_index));
    cmp_field("arg_length", 16'(want.arg_length), 16'(tok_ch.arg_length));
    cmp_field("arg_count", 16'(want.arg_count), 16'(tok_ch.arg_count));
    cmp_field("error_code", 16'(want.error_code), 16'(tok_ch.error_code));
    cmp_field("last", 16'(want.last), 16'(tok_ch.last));
  endtask

  // Token receiver: random ready gaps, one long hold-off on request
  initial begin
    int gap;
    tok_ch.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        // hold ready low long enough for the input queue to fill and stall
        tok_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = pick_gap(rx_swap, rx_quiet);
      if (gap != 0) begin
        tok_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      tok_ch.ready <= 1'b1;
      do @(posedge clk); while (!tok_ch.valid);
      check_token();
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    bit mode;
    char_ch.valid     = 1'b0;
    char_ch.op        = OP_CHAR;
    char_ch.char_code = 8'h00;
    cfg_we            = 1'b0;
    cfg_data          = 1'b0;
    n_errors          = 0;
    burst_send        = 1'b0;
    hold_req          = 1'b0;
    tx_swap           = 0;
    rx_swap           = 0;
    collapse_mode     = 1'b1;
    clear_msg();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table, run with space_mode still at its reset value (collapse).
    // Rows with a typed token are checked against it; the rest go through
    // the model.
    queue_req(OP_END, 8'h00, 1'b1, err_res(ERR_EMPTY));     // empty message
    queue_req(OP_CHAR, 8'hFF, 1'b1, mk_res(KIND_BYTE, 8'hFF, 0, 0, 0));
    queue_req(OP_CHAR, CH_QUOTE);                            // quoted space kept
    queue_req(OP_CHAR, CH_SPACE);
    queue_req(OP_CHAR, CH_QUOTE);
    queue_req(OP_CHAR, CH_SPACE);                            // run of spaces, one break
    queue_req(OP_CHAR, CH_SPACE);
    queue_req(OP_CHAR, CH_AT);                               // escaped quote
    queue_req(OP_CHAR, CH_QUOTE);
    queue_req(OP_CHAR, CH_SLASH);                            // slash, tab, "-0Xg": minus zero, bare X
    queue_req(OP_CHAR, CH_TAB_LO);
    queue_req(OP_CHAR, CH_MINUS);
    queue_req(OP_CHAR, CH_ZERO);
    queue_req(OP_CHAR, CH_UP_X);
    queue_req(OP_CHAR, CH_LO_G);
    queue_req(OP_CHAR, CH_SLASH);                            // bare 0x at end of message
    queue_req(OP_CHAR, CH_ZERO);
    queue_req(OP_CHAR, CH_LO_X);
    queue_req(OP_END, 8'hFF);
    queue_req(OP_CHAR, CH_AT);
    queue_req(OP_END, 8'h00, 1'b1, err_res(ERR_TRAIL_ESC));
    queue_req(OP_CHAR, CH_SLASH);
    queue_req(OP_END, 8'h00, 1'b1, err_res(ERR_NO_NUMBER));
    queue_req(OP_CHAR, CH_QUOTE);
    queue_req(OP_END, 8'h00, 1'b1, err_res(ERR_OPEN_QUOTE));
    queue_req(OP_CHAR, CH_SLASH);                            // "/-1", closed by byte 0
    queue_req(OP_CHAR, CH_MINUS);
    queue_req(OP_CHAR, CH_ZERO + 8'd1);
    queue_req(OP_CHAR, 8'h00, 1'b1, err_res(ERR_BAD_CODE));
    run_jobs();
    settle();

    // Random phases, each under its own space_mode
    for (int p = 1; p <= 8; p++) begin
      case (p)
        1, 4:    mode = 1'b0;
        2, 7:    mode = 1'b1;
        default: mode = 1'($urandom_range(0, 1));
      endcase
      write_space_mode(mode);
      if (p == 4 || p == 7) gen_many_args();
      while (job_q.size() < PHASE_REQS) begin
        if ($urandom_range(0, 6) == 0) gen_noise();
        else gen_message();
      end
      // one phase runs back-to-back requests into a long receiver stall
      burst_send = (p == 5);
      hold_req   = (p == 5);
      run_jobs();
      settle();
      burst_send = 1'b0;
    end

    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop in case the block hangs
  initial begin
    #(20_000_000);
    $display("timeout with %0d tokens outstanding", tokens_due.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
